// ===== design/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants for the compacting array list
// Request and status codes, controller states, cell control group and the
// depth of the gather tree.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int REQ_W    = 2;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int FAN_IN   = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_POP    = 2'd1,
    REQ_READ   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_REDUCE  = 2'd1,
    ST_DELIVER = 2'd2
  } state_t;

  typedef struct packed {
    logic append_en;
    logic remove_en;
    logic capture_en;
  } cell_ctrl_t;

  // registered levels of the sixteen-way gather tree
  function automatic int tree_levels(input int leaves);
    int lg;
    lg = $clog2(leaves);
    return (lg + 3) / 4;
  endfunction

endpackage

// ===== design/compacting_array_list_core.sv =====
// ----------------------------------------------------------------------------
// compacting_array_list_core: bounded ordered word list with remove-at-index
// Requests append, pop, read at index or remove at index; each request gives
// one result with status, count and free places.
// ----------------------------------------------------------------------------
// usage
//   input channel in_*: one request per transaction (req_type, data_in, index)
//   result channel out_*: one result per request, in request order
//   the list lives in a row of DEPTH cells; remove shifts all later cells
//   down by one in the same cycle the request is taken
//   the selected word reaches the output through a sixteen-way registered
//   gather tree of L = ceil(log2(DEPTH)/4) levels (2 at DEPTH 256)
//   order: the request is accepted, the tree levels reduce in ST_REDUCE, then
//   ST_DELIVER loads the output register and out_valid rises; no new request
//   is taken until then, and in_stall is high while a request is in flight
//   when the receiver stalls, the result waits in the output register and
//   the next result is held in ST_DELIVER until that register is free
//   reset: the list is empty; stored words are undefined until written
// ----------------------------------------------------------------------------
module compacting_array_list_core #(
  parameter int DEPTH      = 256,
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cal_pkg::REQ_W-1:0]    in_req_type,
  input  logic [cal_pkg::DATA_W-1:0]   in_data_in,
  input  logic [cal_pkg::INDEX_W-1:0]  in_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cal_pkg::DATA_W-1:0]   out_data_out,
  output logic [cal_pkg::STATUS_W-1:0] out_status,
  output logic [cal_pkg::COUNT_W-1:0]  out_item_count,
  output logic [cal_pkg::COUNT_W-1:0]  out_free_places
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int CMPW     = (CW > cal_pkg::INDEX_W) ? CW : cal_pkg::INDEX_W;
  localparam int CXW      = CW + cal_pkg::COUNT_W;
  localparam int DXW      = WORD_WIDTH + cal_pkg::DATA_W;
  localparam int TREE_LAT = cal_pkg::tree_levels(DEPTH);
  localparam int LAT_W    = $clog2(TREE_LAT + 1);
  localparam logic [CW-1:0]    FullCount = CW'(DEPTH);
  localparam logic [LAT_W-1:0] LatLast   = LAT_W'(TREE_LAT - 1);

  cal_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [LAT_W-1:0]    lat_r;
  logic                want_data_r;
  cal_pkg::status_t    status_r;
  logic                out_valid_r;
  logic [cal_pkg::DATA_W-1:0]  out_data_r;
  logic [cal_pkg::STATUS_W-1:0] out_status_r;
  logic [cal_pkg::COUNT_W-1:0] out_count_r;
  logic [cal_pkg::COUNT_W-1:0] out_free_r;

  logic                accept;
  logic                out_free;
  logic                load_out;
  cal_pkg::req_t       req;
  cal_pkg::status_t    status_d;
  logic                want_data_d;
  logic                full;
  logic                empty;
  logic                in_range;
  logic [CMPW-1:0]     idx_ext;
  logic [CMPW-1:0]     cnt_ext;
  cal_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]       sel_pos;
  logic [DXW-1:0]      din_ext;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [WORD_WIDTH-1:0] cell_word [DEPTH];
  logic [WORD_WIDTH-1:0] cell_tap  [DEPTH];
  logic [WORD_WIDTH-1:0] root;
  logic [DXW-1:0]      root_ext;
  logic [CXW-1:0]      cnt_wide;
  logic [CXW-1:0]      free_wide;

  assign accept  = in_valid && !in_stall;
  assign req     = cal_pkg::req_t'(in_req_type);
  assign idx_ext = CMPW'(in_index);
  assign cnt_ext = CMPW'(count_r);
  assign full    = (count_r == FullCount);
  assign empty   = (count_r == '0);
  assign in_range = (idx_ext < cnt_ext);
  assign din_ext = DXW'(in_data_in);
  assign wr_data = din_ext[WORD_WIDTH-1:0];

  // request decode
  always_comb begin
    status_d    = cal_pkg::STATUS_OK;
    want_data_d = 1'b0;
    ctrl        = '0;
    sel_pos     = CW'(in_index);
    count_nxt   = count_r;
    unique case (req)
      cal_pkg::REQ_APPEND: begin
        if (full) begin
          status_d = cal_pkg::STATUS_FULL;
        end else begin
          ctrl.append_en = accept;
          count_nxt      = count_r + 1'b1;
        end
      end
      cal_pkg::REQ_POP: begin
        sel_pos = count_r - 1'b1;
        if (empty) begin
          status_d = cal_pkg::STATUS_RANGE;
        end else begin
          want_data_d = 1'b1;
          count_nxt   = count_r - 1'b1;
        end
      end
      cal_pkg::REQ_READ: begin
        if (!in_range) begin
          status_d = cal_pkg::STATUS_RANGE;
        end else begin
          want_data_d = 1'b1;
        end
      end
      cal_pkg::REQ_REMOVE: begin
        if (!in_range) begin
          status_d = cal_pkg::STATUS_RANGE;
        end else begin
          want_data_d    = 1'b1;
          ctrl.remove_en = accept;
          count_nxt      = count_r - 1'b1;
        end
      end
    endcase
    ctrl.capture_en = accept;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cell_word[i+1];
    end else begin : g_last
      assign nbr = cell_word[i];
    end
    cal_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .append_pos (count_r),
      .sel_pos    (sel_pos),
      .wr_data    (wr_data),
      .next_word  (nbr),
      .word       (cell_word[i]),
      .tap        (cell_tap[i])
    );
  end

  cal_or_tree #(
    .LEAVES     (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_tree (
    .clk  (clk),
    .taps (cell_tap),
    .root (root)
  );

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cal_pkg::ST_IDLE: begin
        if (accept) state_nxt = cal_pkg::ST_REDUCE;
      end
      cal_pkg::ST_REDUCE: begin
        if (lat_r == LatLast) state_nxt = cal_pkg::ST_DELIVER;
      end
      cal_pkg::ST_DELIVER: begin
        if (out_free) state_nxt = cal_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state_r)
      cal_pkg::ST_IDLE:    in_stall = 1'b0;
      cal_pkg::ST_REDUCE:  in_stall = 1'b1;
      cal_pkg::ST_DELIVER: load_out = out_free;
    endcase
  end

  assign root_ext  = DXW'(root);
  assign cnt_wide  = CXW'(count_r);
  assign free_wide = CXW'(FullCount - count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cal_pkg::ST_IDLE;
      count_r     <= '0;
      lat_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
        lat_r   <= '0;
      end else if (state_r == cal_pkg::ST_REDUCE) begin
        lat_r <= lat_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_d;
      want_data_r <= want_data_d;
    end
    if (load_out) begin
      out_data_r   <= want_data_r ? root_ext[cal_pkg::DATA_W-1:0] : '0;
      out_status_r <= status_r;
      out_count_r  <= cnt_wide[cal_pkg::COUNT_W-1:0];
      out_free_r   <= free_wide[cal_pkg::COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_item_count  = out_count_r;
  assign out_free_places = out_free_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCount)
    else $error("item count above capacity");

  a_full_append_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req == cal_pkg::REQ_APPEND) && full |=> $stable(count_r))
    else $error("refused append changed the count");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (req == cal_pkg::REQ_REMOVE) && in_range
    |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink the list by one");

  a_result_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == cal_pkg::ST_DELIVER))
    else $error("result raised outside deliver");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cal_pkg::ST_REDUCE) || (state_r == cal_pkg::ST_DELIVER) |-> !accept)
    else $error("request taken while one is in flight");

endmodule

// ===== design/cal_cell.sv =====
// ----------------------------------------------------------------------------
// cal_cell: one storage place of the list
// Holds one word, writes it on append at its position, takes the word of its
// right neighbor when a remove opens a gap at or before it, and captures its
// word into a tap register when it is the selected position.
// ----------------------------------------------------------------------------
module cal_cell #(
  parameter int WORD_WIDTH = 32,
  parameter int CW         = 9,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cal_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]         append_pos,
  input  logic [CW-1:0]         sel_pos,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic [WORD_WIDTH-1:0] next_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic [WORD_WIDTH-1:0] tap
);

  localparam logic [CW-1:0] MyPos = CW'(IDX);

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] tap_r;

  always_ff @(posedge clk) begin
    if (ctrl.append_en && (append_pos == MyPos)) begin
      word_r <= wr_data;
    end else if (ctrl.remove_en && (MyPos >= sel_pos)) begin
      word_r <= next_word;
    end
    if (ctrl.capture_en) begin
      tap_r <= (sel_pos == MyPos) ? word_r : '0;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule

// ===== design/cal_or_tree.sv =====
// ----------------------------------------------------------------------------
// cal_or_tree: registered gather tree
// OR-reduces the cell taps sixteen at a time, one registered level per cycle;
// at most one tap is nonzero, so the root is the selected word.
// ----------------------------------------------------------------------------
module cal_or_tree #(
  parameter int LEAVES     = 256,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [WORD_WIDTH-1:0] taps [LEAVES],
  output logic [WORD_WIDTH-1:0] root
);

  localparam int LV    = cal_pkg::tree_levels(LEAVES);
  localparam int PAD   = 1 << (4 * LV);
  localparam int FAN   = cal_pkg::FAN_IN;

  function automatic int lvl_base(input int k);
    int b;
    b = 0;
    for (int j = 1; j < k; j++) begin
      b += PAD >> (4 * j);
    end
    return b;
  endfunction

  localparam int NODES = lvl_base(LV + 1);

  logic [WORD_WIDTH-1:0] node_r   [NODES];
  logic [WORD_WIDTH-1:0] node_nxt [NODES];

  always_comb begin
    logic [WORD_WIDTH-1:0] acc;
    int src;
    for (int k = 1; k <= LV; k++) begin
      for (int n = 0; n < (PAD >> (4 * k)); n++) begin
        acc = '0;
        for (int m = 0; m < FAN; m++) begin
          src = n * FAN + m;
          if (k == 1) begin
            if (src < LEAVES) begin
              acc |= taps[src];
            end
          end else begin
            acc |= node_r[lvl_base(k - 1) + src];
          end
        end
        node_nxt[lvl_base(k) + n] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign root = node_r[NODES-1];

endmodule
